// ===== hdl/lwpg_pkg.sv =====
// Shared types, constants and lookup tables for the LOS waypoint guidance unit.
// Used by lwpg_cordic, lwpg_mul and los_waypoint_path_guidance_unit.
`default_nettype none
package lwpg_pkg;

  localparam int MaxWaypoints = 64;
  localparam int IdxW = $clog2(MaxWaypoints);
  localparam int CntW = $clog2(MaxWaypoints + 1);
  localparam int CfgW = 26;
  localparam int CfgIdxW = 2;

  localparam int CordW = 36;
  localparam int CordZW = 34;
  localparam int CordSteps = 24;
  localparam int CordIW = 5;

  localparam int MulAW = 36;
  localparam int MulBW = 32;
  localparam int MulPW = MulAW + MulBW;

  localparam logic [1:0] CmdAppend = 2'd0;
  localparam logic [1:0] CmdPos    = 2'd1;
  localparam logic [1:0] CmdClear  = 2'd2;

  localparam logic [1:0] StOk       = 2'd0;
  localparam logic [1:0] StFull     = 2'd1;
  localparam logic [1:0] StNoPath   = 2'd2;
  localparam logic [1:0] StFinished = 2'd3;

  localparam logic [CfgIdxW-1:0] CfgLookMin = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgLookMax = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgSwitch  = 2'd2;

  localparam logic [CfgW-1:0] LookMinRst = 26'd65536;
  localparam logic [CfgW-1:0] LookMaxRst = 26'd327680;
  localparam logic [CfgW-1:0] SwitchRst  = 26'd131072;

  localparam logic [31:0] InvGainQ30 = 32'd652032874;
  localparam logic [31:0] InvGainQ28 = 32'd163008219;
  localparam logic [31:0] C03Q16     = 32'd19661;
  localparam logic [31:0] Log2eQ16   = 32'd94548;
  localparam logic [32:0] SevenMQ16  = 33'd458752;
  localparam logic [25:0] OneQ16     = 26'd65536;

  typedef enum logic {CordVec, CordRot} lwpg_cmode_e;

  typedef struct packed {
    logic [1:0]         cmd;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
  } lwpg_in_t;

  typedef struct packed {
    logic signed [15:0] cmd_heading;
    logic signed [31:0] cross_track_error;
    logic signed [31:0] along_track_error;
    logic [5:0]         segment_index;
    logic               active;
    logic [1:0]         status;
  } lwpg_out_t;

  function automatic logic [31:0] atan_lut(input logic [CordIW-1:0] i);
    logic [31:0] r;
    case (i)
      5'd0:  r = 32'h20000000;
      5'd1:  r = 32'h12E4051D;
      5'd2:  r = 32'h09FB385B;
      5'd3:  r = 32'h051111D4;
      5'd4:  r = 32'h028B0D43;
      5'd5:  r = 32'h0145D7E1;
      5'd6:  r = 32'h00A2F61E;
      5'd7:  r = 32'h00517C55;
      5'd8:  r = 32'h0028BE53;
      5'd9:  r = 32'h00145F2E;
      5'd10: r = 32'h000A2F98;
      5'd11: r = 32'h000517CC;
      5'd12: r = 32'h00028BE6;
      5'd13: r = 32'h000145F3;
      5'd14: r = 32'h0000A2F9;
      5'd15: r = 32'h0000517C;
      5'd16: r = 32'h000028BE;
      5'd17: r = 32'h0000145F;
      5'd18: r = 32'h00000A2F;
      5'd19: r = 32'h00000517;
      5'd20: r = 32'h0000028B;
      5'd21: r = 32'h00000145;
      5'd22: r = 32'h000000A2;
      5'd23: r = 32'h00000051;
      default: r = 32'h0;
    endcase
    return r;
  endfunction

  function automatic logic [16:0] exp2_lut(input logic [4:0] i);
    logic [16:0] r;
    case (i)
      5'd0:  r = 17'd65536;
      5'd1:  r = 17'd62757;
      5'd2:  r = 17'd60097;
      5'd3:  r = 17'd57549;
      5'd4:  r = 17'd55109;
      5'd5:  r = 17'd52773;
      5'd6:  r = 17'd50535;
      5'd7:  r = 17'd48393;
      5'd8:  r = 17'd46341;
      5'd9:  r = 17'd44376;
      5'd10: r = 17'd42495;
      5'd11: r = 17'd40693;
      5'd12: r = 17'd38968;
      5'd13: r = 17'd37316;
      5'd14: r = 17'd35734;
      5'd15: r = 17'd34219;
      5'd16: r = 17'd32768;
      default: r = 17'd0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/lwpg_mul.sv =====
// Shared signed multiplier with a registered product.
// Depends on lwpg_pkg.
`default_nettype none
module lwpg_mul (
  input  wire                                 clk_i,
  input  wire logic signed [lwpg_pkg::MulAW-1:0] a_i,
  input  wire logic signed [lwpg_pkg::MulBW-1:0] b_i,
  output logic signed [lwpg_pkg::MulPW-1:0]      p_o
);
  import lwpg_pkg::*;

  logic signed [MulPW-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= MulPW'(a_i) * MulPW'(b_i);
  end

  assign p_o = p_q;

endmodule
`default_nettype wire

// ===== hdl/lwpg_cordic.sv =====
// Iterative CORDIC, one micro-rotation per cycle, vectoring or rotation mode.
// Depends on lwpg_pkg for widths and the arctangent table.
`default_nettype none
module lwpg_cordic (
  input  wire                                   clk_i,
  input  wire                                   rst_ni,
  input  wire                                   start_i,
  input  wire lwpg_pkg::lwpg_cmode_e            mode_i,
  input  wire logic signed [lwpg_pkg::CordW-1:0] vx_i,
  input  wire logic signed [lwpg_pkg::CordW-1:0] vy_i,
  input  wire logic [15:0]                      ang_i,
  output logic                                  done_o,
  output logic signed [lwpg_pkg::CordW-1:0]     x_o,
  output logic signed [lwpg_pkg::CordW-1:0]     y_o,
  output logic [31:0]                           z_o
);
  import lwpg_pkg::*;

  logic                     busy_q, done_q;
  logic [CordIW-1:0]        i_q;
  lwpg_cmode_e              mode_q;
  logic                     flip_q, zero_q;
  logic signed [CordW-1:0]  x_q, y_q, xs, ys;
  logic signed [CordZW-1:0] z_q, zr, at;

  assign xs = x_q >>> i_q;
  assign ys = y_q >>> i_q;
  assign at = CordZW'(atan_lut(i_q));
  assign zr = {{2{ang_i[15]}}, ang_i, 16'h0};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      i_q    <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        i_q    <= '0;
      end else if (busy_q) begin
        if (i_q == CordIW'(CordSteps - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
        i_q <= i_q + CordIW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      mode_q <= mode_i;
      if (mode_i == CordVec) begin
        zero_q <= (vx_i == '0) && (vy_i == '0);
        flip_q <= 1'b0;
        if (vx_i < 0) begin
          x_q <= -vx_i;
          y_q <= -vy_i;
          z_q <= CordZW'(34'h080000000);
        end else begin
          x_q <= vx_i;
          y_q <= vy_i;
          z_q <= '0;
        end
      end else begin
        zero_q <= 1'b0;
        x_q    <= CordW'(InvGainQ28);
        y_q    <= '0;
        if (zr > CordZW'(34'sh040000000)) begin
          z_q    <= zr - CordZW'(34'sh080000000);
          flip_q <= 1'b1;
        end else if (zr < -CordZW'(34'sh040000000)) begin
          z_q    <= zr + CordZW'(34'sh080000000);
          flip_q <= 1'b1;
        end else begin
          z_q    <= zr;
          flip_q <= 1'b0;
        end
      end
    end else if (busy_q) begin
      if (mode_q == CordVec) begin
        if (y_q >= 0) begin
          x_q <= x_q + ys;
          y_q <= y_q - xs;
          z_q <= z_q + at;
        end else begin
          x_q <= x_q - ys;
          y_q <= y_q + xs;
          z_q <= z_q - at;
        end
      end else begin
        if (z_q >= 0) begin
          x_q <= x_q - ys;
          y_q <= y_q + xs;
          z_q <= z_q - at;
        end else begin
          x_q <= x_q + ys;
          y_q <= y_q - xs;
          z_q <= z_q + at;
        end
      end
    end
  end

  assign done_o = done_q;
  assign x_o = zero_q ? '0 : (flip_q ? -x_q : x_q);
  assign y_o = zero_q ? '0 : (flip_q ? -y_q : y_q);
  assign z_o = zero_q ? '0 : z_q[31:0];

endmodule
`default_nettype wire

// ===== hdl/los_waypoint_path_guidance_unit.sv =====
// Top level of the LOS waypoint guidance unit: sequencer, path memories, output register.
// Depends on lwpg_pkg, lwpg_cordic and lwpg_mul.
//
// Usage: items enter on in_valid_i/in_ready_o (cmd, pos_x, pos_y); each item gives exactly
// one result on out_valid_o/out_ready_i. Registers are written on cfg_valid_i with
// cfg_index_i/cfg_data_i; cfg_ready_o is always high.
// in_ready_o is high only while the sequencer is idle; one item is worked at a time.
// Work per item before its result goes to the output register:
//   clear, ignored command, table full, no path, finished: no datapath work
//   first append: stored only; later appends: one 24-step CORDIC run and one multiply
//   position sample: two 24-step CORDIC runs through one CORDIC unit and up to
//   nine products through one shared multiplier.
// The shared CORDIC and multiplier serve one item at a time: a new item is taken only
// once the last result is in the output register. A finished result sits there; if
// the receiver stalls, the sequencer holds in its last step until the register is free.
// Reset empties the path (count and segment index to zero), loads register defaults
// and drops out_valid_o. Path memory contents are not cleared; only written entries
// are read.
`default_nettype none
module los_waypoint_path_guidance_unit (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire                         in_valid_i,
  output logic                        in_ready_o,
  input  wire lwpg_pkg::lwpg_in_t     in_data_i,
  output logic                        out_valid_o,
  input  wire                         out_ready_i,
  output lwpg_pkg::lwpg_out_t         out_data_o,
  input  wire                         cfg_valid_i,
  output logic                        cfg_ready_o,
  input  wire logic [lwpg_pkg::CfgIdxW-1:0] cfg_index_i,
  input  wire logic [lwpg_pkg::CfgW-1:0]    cfg_data_i
);
  import lwpg_pkg::*;

  localparam int StW = 5;
  localparam logic [StW-1:0] S_IDLE  = 5'd0;
  localparam logic [StW-1:0] S_APRD  = 5'd1;
  localparam logic [StW-1:0] S_APCW  = 5'd2;
  localparam logic [StW-1:0] S_APMUL = 5'd3;
  localparam logic [StW-1:0] S_APWR  = 5'd4;
  localparam logic [StW-1:0] S_PRD   = 5'd5;
  localparam logic [StW-1:0] S_PSW   = 5'd6;
  localparam logic [StW-1:0] S_M1    = 5'd7;
  localparam logic [StW-1:0] S_M2    = 5'd8;
  localparam logic [StW-1:0] S_M3    = 5'd9;
  localparam logic [StW-1:0] S_M4    = 5'd10;
  localparam logic [StW-1:0] S_M5    = 5'd11;
  localparam logic [StW-1:0] S_E1    = 5'd12;
  localparam logic [StW-1:0] S_E2    = 5'd13;
  localparam logic [StW-1:0] S_E3    = 5'd14;
  localparam logic [StW-1:0] S_E4    = 5'd15;
  localparam logic [StW-1:0] S_E5    = 5'd16;
  localparam logic [StW-1:0] S_E6    = 5'd17;
  localparam logic [StW-1:0] S_D1    = 5'd18;
  localparam logic [StW-1:0] S_D2    = 5'd19;
  localparam logic [StW-1:0] S_DW    = 5'd20;
  localparam logic [StW-1:0] S_OUT   = 5'd21;

  function automatic logic signed [31:0] rnd_sat(input logic signed [MulPW-1:0] v);
    logic signed [MulPW-1:0] r;
    r = (v + MulPW'(64'sh8000000)) >>> 28;
    if (r > MulPW'(64'sh7FFFFFFF)) return 32'sh7FFFFFFF;
    if (r < -MulPW'(64'sh80000000)) return 32'sh80000000;
    return r[31:0];
  endfunction

  logic [StW-1:0]  st_q;
  logic [CntW-1:0] cnt_q, cnt_m1;
  logic [IdxW-1:0] cur_q;
  logic            out_valid_q;
  lwpg_out_t       out_q;
  logic [CfgW-1:0] lmin_q, lmax_q, swr_q;

  logic [63:0] xy_mem [MaxWaypoints];
  logic [47:0] seg_mem [MaxWaypoints];
  logic [63:0] xy_rdata_q;
  logic [47:0] seg_rdata_q;
  logic        xy_we, seg_we;
  logic [IdxW-1:0] xy_raddr;
  logic [47:0] seg_wdata;

  logic signed [31:0] px_q, py_q;
  logic signed [32:0] dx_q, dy_q;
  logic [15:0]        ang_q;
  logic [31:0]        len_q;
  logic signed [MulPW-1:0] acc_q;
  logic signed [31:0] ate_q, cte_q;
  logic signed [15:0] heading_q;
  logic [1:0]         status_q;
  logic [16:0]        fac_q, lo_q;
  logic [11:0]        diff_q, frac_q;
  logic [4:0]         n_q;

  logic accept, full, acc_adv;
  logic [1:0] acc_status;

  logic                     cord_start, cord_done;
  lwpg_cmode_e              cord_mode;
  logic signed [CordW-1:0]  cord_vx, cord_vy, cord_x, cord_y;
  logic [31:0]              cord_z;

  logic signed [MulAW-1:0] mul_a;
  logic signed [MulBW-1:0] mul_b;
  logic signed [MulPW-1:0] mul_p;

  logic [32:0] m_abs;
  logic        m_big;
  logic [MulPW-1:0] u_sum, v_sum, w_sum, mag_sum, d_sum;
  logic [20:0] u_val;
  logic [5:0]  v_n;
  logic [15:0] v_f;
  logic [16:0] e_lo, e_hi, e_val;
  logic [17:0] e_half;
  logic signed [26:0] lk_diff;
  logic signed [28:0] delta;
  logic [31:0] ang_sum, hd_sum, seg_len;
  logic [37:0] mag;
  logic signed [33:0] end_dist;
  logic [33:0] dist_abs;
  logic [25:0] limit;
  logic signed [31:0] rx, ry;

  assign in_ready_o  = (st_q == S_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign cnt_m1      = cnt_q - CntW'(1);
  assign full        = (cnt_q >= CntW'(MaxWaypoints));

  always_comb begin
    acc_status = StOk;
    case (in_data_i.cmd)
      CmdAppend: if (full) acc_status = StFull;
      CmdPos: begin
        if (cnt_q < CntW'(2)) acc_status = StNoPath;
        else if ({1'b0, cur_q} >= cnt_m1) acc_status = StFinished;
      end
      default: acc_status = StOk;
    endcase
  end
  assign acc_adv = (acc_status == StOk);

  // path memories
  assign xy_we    = accept && (in_data_i.cmd == CmdAppend) && !full;
  assign xy_raddr = (in_data_i.cmd == CmdAppend) ? cnt_m1[IdxW-1:0] : cur_q;
  assign seg_we   = (st_q == S_APWR);
  assign rx       = xy_rdata_q[63:32];
  assign ry       = xy_rdata_q[31:0];

  always_ff @(posedge clk_i) begin
    if (xy_we) xy_mem[cnt_q[IdxW-1:0]] <= {in_data_i.pos_x, in_data_i.pos_y};
    xy_rdata_q <= xy_mem[xy_raddr];
    if (seg_we) seg_mem[cnt_m1[IdxW-1:0]] <= seg_wdata;
    seg_rdata_q <= seg_mem[cur_q];
  end

  // shared units
  assign cord_start = (st_q == S_APRD) || (st_q == S_PRD) || (st_q == S_D2);
  assign cord_mode  = (st_q == S_PRD) ? CordRot : CordVec;

  always_comb begin
    if (st_q == S_APRD) begin
      cord_vx = CordW'(px_q) - CordW'(rx);
      cord_vy = CordW'(py_q) - CordW'(ry);
    end else begin
      cord_vx = CordW'(delta);
      cord_vy = -CordW'(cte_q);
    end
  end

  lwpg_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cord_start),
    .mode_i  (cord_mode),
    .vx_i    (cord_vx),
    .vy_i    (cord_vy),
    .ang_i   (seg_rdata_q[47:32]),
    .done_o  (cord_done),
    .x_o     (cord_x),
    .y_o     (cord_y),
    .z_o     (cord_z)
  );

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (st_q)
      S_APMUL: begin mul_a = cord_x;           mul_b = InvGainQ30;       end
      S_M1:    begin mul_a = MulAW'(dx_q);     mul_b = cord_x[31:0];     end
      S_M2:    begin mul_a = MulAW'(dy_q);     mul_b = cord_y[31:0];     end
      S_M3:    begin mul_a = MulAW'(dy_q);     mul_b = cord_x[31:0];     end
      S_M4:    begin mul_a = MulAW'(dx_q);     mul_b = cord_y[31:0];     end
      S_E1:    begin mul_a = {3'b0, m_abs};    mul_b = C03Q16;           end
      S_E2:    begin mul_a = mul_p[MulAW-1:0]; mul_b = m_abs[31:0];      end
      S_E3:    begin mul_a = {15'b0, u_val};   mul_b = Log2eQ16;         end
      S_E5:    begin mul_a = {24'b0, diff_q};  mul_b = {20'b0, frac_q};  end
      S_D1:    begin mul_a = MulAW'(lk_diff);  mul_b = {15'b0, fac_q};   end
      default: begin mul_a = '0;               mul_b = '0;               end
    endcase
  end

  lwpg_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  // datapath helpers
  assign m_abs   = cte_q[31] ? (33'd0 - {cte_q[31], cte_q}) : {1'b0, cte_q};
  assign m_big   = (m_abs >= SevenMQ16);
  assign u_sum   = mul_p + MulPW'(64'h80000000);
  assign u_val   = u_sum[52:32];
  assign v_sum   = mul_p + MulPW'(64'h8000);
  assign v_n     = v_sum[37:32];
  assign v_f     = v_sum[31:16];
  assign e_lo    = exp2_lut({1'b0, v_f[15:12]});
  assign e_hi    = exp2_lut({1'b0, v_f[15:12]} + 5'd1);
  assign w_sum   = mul_p + MulPW'(64'd2048);
  assign e_val   = lo_q - w_sum[28:12];
  assign e_half  = (n_q == 5'd0) ? 18'd0 : (18'd1 << (n_q - 5'd1));
  assign lk_diff = $signed({1'b0, lmax_q}) - $signed({1'b0, lmin_q});
  assign d_sum   = mul_p + MulPW'(64'h8000);
  assign delta   = $signed(d_sum[44:16]) + $signed({3'b0, lmin_q});
  assign mag_sum = mul_p + MulPW'(64'h20000000);
  assign mag     = mag_sum[67:30];
  assign seg_len = (cord_x <= 0) ? 32'd0 : ((|mag[37:32]) ? 32'hFFFFFFFF : mag[31:0]);
  assign ang_sum = cord_z + 32'h8000;
  assign seg_wdata = {ang_sum[31:16], seg_len};
  assign hd_sum  = {ang_q, 16'h0} + cord_z + 32'h8000;
  assign end_dist = $signed({2'b0, len_q}) - $signed({{2{ate_q[31]}}, ate_q});
  assign dist_abs = end_dist[33] ? (34'd0 - end_dist) : end_dist;
  assign limit   = ({1'b0, cur_q} + CntW'(2) < cnt_q) ? swr_q : OneQ16;

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= S_IDLE;
      cnt_q       <= '0;
      cur_q       <= '0;
      out_valid_q <= 1'b0;
      lmin_q      <= LookMinRst;
      lmax_q      <= LookMaxRst;
      swr_q       <= SwitchRst;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          CfgLookMin: lmin_q <= cfg_data_i;
          CfgLookMax: lmax_q <= cfg_data_i;
          CfgSwitch:  swr_q  <= cfg_data_i;
          default: ;
        endcase
      end
      if (out_valid_q && out_ready_i && (st_q != S_OUT)) out_valid_q <= 1'b0;
      unique case (st_q)
        S_IDLE: begin
          if (accept) begin
            st_q <= S_OUT;
            case (in_data_i.cmd)
              CmdAppend: begin
                if (!full) begin
                  if (cnt_q == '0) cnt_q <= CntW'(1);
                  else st_q <= S_APRD;
                end
              end
              CmdPos:   if (acc_adv) st_q <= S_PRD;
              CmdClear: begin
                cnt_q <= '0;
                cur_q <= '0;
              end
              default: ;
            endcase
          end
        end
        S_APRD:  st_q <= S_APCW;
        S_APCW:  if (cord_done) st_q <= S_APMUL;
        S_APMUL: st_q <= S_APWR;
        S_APWR: begin
          cnt_q <= cnt_q + CntW'(1);
          st_q  <= S_OUT;
        end
        S_PRD:   st_q <= S_PSW;
        S_PSW:   if (cord_done) st_q <= S_M1;
        S_M1:    st_q <= S_M2;
        S_M2:    st_q <= S_M3;
        S_M3:    st_q <= S_M4;
        S_M4:    st_q <= S_M5;
        S_M5:    st_q <= S_E1;
        S_E1:    st_q <= m_big ? S_D1 : S_E2;
        S_E2:    st_q <= S_E3;
        S_E3:    st_q <= S_E4;
        S_E4:    st_q <= (v_n >= 6'd17) ? S_D1 : S_E5;
        S_E5:    st_q <= S_E6;
        S_E6:    st_q <= S_D1;
        S_D1:    st_q <= S_D2;
        S_D2:    st_q <= S_DW;
        S_DW: begin
          if (cord_done) begin
            if (dist_abs < {8'b0, limit}) cur_q <= cur_q + IdxW'(1);
            st_q <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            st_q        <= S_IDLE;
          end
        end
        default: st_q <= S_IDLE;
      endcase
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    case (st_q)
      S_IDLE: begin
        if (accept) begin
          px_q      <= in_data_i.pos_x;
          py_q      <= in_data_i.pos_y;
          heading_q <= '0;
          cte_q     <= '0;
          ate_q     <= '0;
          status_q  <= acc_status;
        end
      end
      S_PRD: begin
        dx_q  <= 33'(px_q) - 33'(rx);
        dy_q  <= 33'(py_q) - 33'(ry);
        ang_q <= seg_rdata_q[47:32];
        len_q <= seg_rdata_q[31:0];
      end
      S_M2: acc_q <= mul_p;
      S_M3: ate_q <= rnd_sat(acc_q + mul_p);
      S_M4: acc_q <= mul_p;
      S_M5: cte_q <= rnd_sat(acc_q - mul_p);
      S_E1: if (m_big) fac_q <= '0;
      S_E4: begin
        n_q    <= v_n[4:0];
        lo_q   <= e_lo;
        diff_q <= 12'(e_lo - e_hi);
        frac_q <= v_f[11:0];
        if (v_n >= 6'd17) fac_q <= '0;
      end
      S_E6: fac_q <= 17'((18'(e_val) + e_half) >> n_q);
      S_DW: if (cord_done) heading_q <= hd_sum[31:16];
      S_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_q.cmd_heading       <= heading_q;
          out_q.cross_track_error <= cte_q;
          out_q.along_track_error <= ate_q;
          out_q.segment_index     <= 6'(cur_q);
          out_q.active            <= (cnt_q >= CntW'(2)) && ({1'b0, cur_q} < cnt_m1);
          out_q.status            <= status_q;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_cur_le_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, cur_q} <= cnt_q))
    else $error("segment index beyond waypoint count");

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q <= CntW'(MaxWaypoints)))
    else $error("waypoint count overflow");

  a_cord_done_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cord_done |-> (st_q == S_APCW || st_q == S_PSW || st_q == S_DW))
    else $error("CORDIC finished outside a wait step");

endmodule
`default_nettype wire

// ===== tb/los_waypoint_path_guidance_unit_test.sv =====
// Self-checking testbench for los_waypoint_path_guidance_unit: waypoint paths, position
// samples and register settings checked against a built-in bit-exact guidance predictor.
// Depends on lwpg_pkg and the unit's RTL.
`default_nettype none
module los_waypoint_path_guidance_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import lwpg_pkg::*;

  localparam logic [1:0] CmdNop = 2'd3;
  localparam logic [CfgIdxW-1:0] CfgUnused = 2'd3;
  localparam int StallLimit = 3000;
  localparam int HoldCycles = 500;
  localparam longint unsigned MagSat = 64'hFFFF_FFFF;

  localparam logic [31:0] AtanTab [24] = '{
    32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2E, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C, 32'h000028BE, 32'h0000145F,
    32'h00000A2F, 32'h00000517, 32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051};
  localparam longint Exp2Tab [17] = '{65536, 62757, 60097, 57549, 55109, 52773, 50535,
    48393, 46341, 44376, 42495, 40693, 38968, 37316, 35734, 34219, 32768};

  logic clk_i, rst_ni;
  logic in_valid_i, in_ready_o, out_valid_o, out_ready_i;
  logic cfg_valid_i, cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i;
  logic [CfgW-1:0] cfg_data_i;
  lwpg_in_t in_data_i;
  lwpg_out_t out_data_o;

  los_waypoint_path_guidance_unit DUT (.*);

  // guidance state mirror
  logic signed [31:0] path_x [MaxWaypoints];
  logic signed [31:0] path_y [MaxWaypoints];
  logic [15:0] leg_angle [MaxWaypoints];
  logic [31:0] leg_length [MaxWaypoints];
  int unsigned n_waypoints, leg;
  longint look_min, look_max, switch_dist;

  lwpg_in_t pending_items [$];
  lwpg_out_t expected_guidance [$];
  int gap, stall, hold_cnt, mismatches, n_in, n_out, quiet_cycles;
  int n_tracked;
  bit hold_done;

  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 80) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [31:0] vec_angle(input longint x0, input longint y0,
                                            output longint unsigned mag);
    longint x, y, xs, ys;
    logic [31:0] z;
    x = x0;
    y = y0;
    z = '0;
    mag = 0;
    if (x == 0 && y == 0) return '0;
    if (x < 0) begin
      x = -x;
      y = -y;
      z = 32'h8000_0000;
    end
    for (int i = 0; i < 24; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x += ys; y -= xs; z += AtanTab[i];
      end else begin
        x -= ys; y += xs; z -= AtanTab[i];
      end
    end
    if (x > 0) mag = (longint'(x) * 64'd652032874 + (64'd1 << 29)) >> 30;
    return z;
  endfunction

  function automatic logic [15:0] round_angle(input logic [31:0] z);
    logic [31:0] t;
    t = z + 32'h8000;
    return t[31:16];
  endfunction

  function automatic void rotate_unit(input logic [15:0] a, output longint c,
                                      output longint s);
    longint z, x, y, xs, ys;
    bit flip;
    z = longint'($signed(a)) * 65536;
    x = 163008219;
    y = 0;
    flip = 0;
    if (z > 64'sh4000_0000) begin
      z -= 64'sh8000_0000; flip = 1;
    end else if (z < -64'sh4000_0000) begin
      z += 64'sh8000_0000; flip = 1;
    end
    for (int i = 0; i < 24; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x -= ys; y += xs; z -= longint'(AtanTab[i]);
      end else begin
        x += ys; y -= xs; z += longint'(AtanTab[i]);
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  function automatic longint error_weight(input longint e);
    longint unsigned m, u, v, f, n;
    longint lo, hi, val;
    m = (e < 0) ? -e : e;
    if (m >= 458752) return 0;
    u = (m * m * 19661 + (64'd1 << 31)) >> 32;
    v = (u * 94548 + 64'h8000) >> 16;
    n = v >> 16;
    f = v & 64'hFFFF;
    if (n >= 17) return 0;
    lo = Exp2Tab[f >> 12];
    hi = Exp2Tab[(f >> 12) + 1];
    val = lo - (((lo - hi) * longint'(f & 64'hFFF) + 2048) >>> 12);
    return (val + ((longint'(1) << n) >>> 1)) >>> n;
  endfunction

  function automatic longint clamp32(input longint v);
    if (v > 64'sh7FFF_FFFF) return 64'sh7FFF_FFFF;
    if (v < -64'sh8000_0000) return -64'sh8000_0000;
    return v;
  endfunction

  function automatic lwpg_out_t guide(input lwpg_in_t it);
    lwpg_out_t r;
    longint px, py, c, s, dx, dy, delta, end_dist, limit, cte, ate;
    longint unsigned mag;
    logic [31:0] z;
    int unsigned k;
    r = '0;
    px = it.pos_x;
    py = it.pos_y;
    case (it.cmd)
      CmdAppend: begin
        if (n_waypoints >= MaxWaypoints) r.status = StFull;
        else begin
          k = n_waypoints;
          path_x[k] = it.pos_x;
          path_y[k] = it.pos_y;
          if (k >= 1) begin
            z = vec_angle(px - path_x[k-1], py - path_y[k-1], mag);
            leg_angle[k-1] = round_angle(z);
            leg_length[k-1] = (mag > MagSat) ? 32'hFFFF_FFFF : mag[31:0];
          end
          n_waypoints = k + 1;
        end
      end
      CmdClear: begin
        n_waypoints = 0;
        leg = 0;
      end
      CmdPos: begin
        if (n_waypoints < 2) r.status = StNoPath;
        else if (leg >= n_waypoints - 1) r.status = StFinished;
        else begin
          k = leg;
          rotate_unit(leg_angle[k], c, s);
          dx = px - path_x[k];
          dy = py - path_y[k];
          ate = clamp32((dx * c + dy * s + (64'sd1 <<< 27)) >>> 28);
          cte = clamp32((dy * c - dx * s + (64'sd1 <<< 27)) >>> 28);
          delta = (((look_max - look_min) * error_weight(cte) + 64'sh8000) >>> 16) + look_min;
          z = vec_angle(delta, -cte, mag);
          r.cmd_heading = round_angle({leg_angle[k], 16'h0} + z);
          r.cross_track_error = cte[31:0];
          r.along_track_error = ate[31:0];
          end_dist = longint'(leg_length[k]) - ate;
          if (end_dist < 0) end_dist = -end_dist;
          limit = (k < n_waypoints - 2) ? switch_dist : 65536;
          if (end_dist < limit) leg = k + 1;
        end
      end
      default: ;
    endcase
    r.segment_index = leg[5:0];
    r.active = (n_waypoints >= 2 && leg < n_waypoints - 1);
    return r;
  endfunction

  // input driver
  always @(posedge clk_i or negedge rst_ni) begin
    bit taken;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i <= '0;
      gap <= 0;
      n_in <= 0;
    end else begin
      taken = in_valid_i && in_ready_o;
      if (taken) begin
        expected_guidance.insert(expected_guidance.size(), guide(in_data_i));
        void'(pending_items.pop_front());
        n_in <= n_in + 1;
      end
      if (in_valid_i && !taken) begin
      end else if (gap > 0) begin
        gap <= gap - 1;
        in_valid_i <= 1'b0;
      end else if (pending_items.size() > 0) begin
        in_valid_i <= 1'b1;
        in_data_i <= pending_items[0];
        gap <= pick_gap();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // result receiver, with one long hold-off to back the unit up
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      stall <= 0;
      hold_cnt <= 0;
      hold_done <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      out_ready_i <= 1'b0;
    end else if (!hold_done && n_in >= 250) begin
      hold_done <= 1'b1;
      hold_cnt <= HoldCycles;
      out_ready_i <= 1'b0;
    end else if (stall > 0) begin
      stall <= stall - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
      if ($urandom_range(0, 5) == 0) stall <= pick_gap();
    end
  end

  // result checker
  always @(posedge clk_i) begin
    lwpg_out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      n_out++;
      if (expected_guidance.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR: unexpected result %p", out_data_o);
      end else begin
        want = expected_guidance.pop_front();
        if (out_data_o !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: result %0d expected %p got %p", n_out, want, out_data_o);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || !rst_ni)
      quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= StallLimit) begin
      $display("los_waypoint_path_guidance_unit_test NOT OK");
      $finish;
    end
  end

  task automatic add_item(input logic [1:0] cmd, input longint x, input longint y);
    lwpg_in_t it;
    it.cmd = cmd;
    it.pos_x = x[31:0];
    it.pos_y = y[31:0];
    if (cmd == CmdPos) n_tracked++;
    pending_items.insert(pending_items.size(), it);
  endtask

  task automatic drain();
    while (pending_items.size() > 0 || in_valid_i || expected_guidance.size() > 0)
      @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input longint value);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value[CfgW-1:0];
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      CfgLookMin: look_min = value[CfgW-1:0];
      CfgLookMax: look_max = value[CfgW-1:0];
      CfgSwitch: switch_dist = value[CfgW-1:0];
      default: ;
    endcase
  endtask

  function automatic longint rand_full();
    return longint'($signed($urandom()));
  endfunction

  function automatic longint noise(input int span);
    return longint'($urandom_range(0, 2 * span)) - span;
  endfunction

  // random path with samples walked along each leg
  task automatic add_route(input int n, input int step);
    longint wx [$], wy [$];
    longint x, y, ex, ey;
    int m;
    add_item(CmdClear, rand_full(), rand_full());
    x = noise(1 << 24);
    y = noise(1 << 24);
    for (int i = 0; i < n; i++) begin
      wx.insert(wx.size(), x);
      wy.insert(wy.size(), y);
      add_item(CmdAppend, x, y);
      x += noise(step);
      y += noise(step);
    end
    if (n >= MaxWaypoints) add_item(CmdAppend, x, y);
    for (int sgi = 0; sgi + 1 < n; sgi++) begin
      m = $urandom_range(1, 3);
      for (int t = 1; t <= m; t++) begin
        ex = ($urandom_range(0, 4) == 0) ? noise(1 << 20) : noise(1 << 15);
        ey = ($urandom_range(0, 4) == 0) ? noise(1 << 20) : noise(1 << 15);
        add_item(CmdPos, wx[sgi] + (wx[sgi+1] - wx[sgi]) * t / m + ex,
                 wy[sgi] + (wy[sgi+1] - wy[sgi]) * t / m + ey);
      end
    end
    add_item(CmdPos, x, y);
    if ($urandom_range(0, 3) == 0) add_item(CmdAppend, x, y);
  endtask

  task automatic random_phase(input int count);
    int start;
    start = pending_items.size() + n_in;
    while (pending_items.size() + n_in < start + count) begin
      if ($urandom_range(0, 9) == 0)
        add_item(2'($urandom_range(0, 3)), rand_full(), rand_full());
      else if ($urandom_range(0, 39) == 0)
        add_route(MaxWaypoints, 1 << 20);
      else add_route($urandom_range(2, 6), ($urandom_range(0, 5) == 0) ? 1 << 30 : 1 << 22);
    end
    drain();
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    mismatches = 0;
    n_out = 0;
    quiet_cycles = 0;
    n_waypoints = 0;
    leg = 0;
    look_min = LookMinRst;
    look_max = LookMaxRst;
    switch_dist = SwitchRst;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed
    add_item(CmdPos, 0, 0);
    add_item(CmdAppend, 0, 0);
    add_item(CmdPos, 65536, 0);
    add_item(CmdNop, -1, -1);
    add_item(CmdAppend, 5 << 16, 0);
    add_item(CmdPos, 1 << 16, 1 << 16);
    add_item(CmdPos, 1 << 16, 8 << 16);
    add_item(CmdPos, 5 << 16, 0);
    add_item(CmdPos, 5 << 16, 0);
    add_item(CmdAppend, 5 << 16, 0);
    add_item(CmdAppend, 5 << 16, 10 << 16);
    add_item(CmdPos, 5 << 16, -(3 << 16));
    add_item(CmdPos, 64'sh7FFF_FFFF, 64'sh7FFF_FFFF);
    add_item(CmdClear, 0, 0);
    add_item(CmdAppend, 64'sh7FFF_FFFF, -64'sh8000_0000);
    add_item(CmdAppend, -64'sh8000_0000, 64'sh7FFF_FFFF);
    add_item(CmdPos, -64'sh8000_0000, -64'sh8000_0000);
    add_item(CmdPos, 64'sh7FFF_FFFF, 64'sh7FFF_FFFF);
    add_item(CmdPos, 0, 0);
    add_item(CmdClear, -1, -1);
    drain();

    random_phase(150);
    write_reg(CfgLookMin, 0);
    write_reg(CfgLookMax, 64'h3FF_FFFF);
    write_reg(CfgSwitch, 64'h3FF_FFFF);
    write_reg(CfgUnused, longint'($urandom()));
    random_phase(150);
    write_reg(CfgLookMin, 64'h3FF_FFFF);
    write_reg(CfgLookMax, 0);
    write_reg(CfgSwitch, 0);
    random_phase(120);
    write_reg(CfgLookMin, longint'($urandom_range(0, 1 << 18)));
    write_reg(CfgLookMax, longint'($urandom_range(1 << 17, 1 << 20)));
    write_reg(CfgSwitch, longint'($urandom_range(1 << 15, 1 << 19)));
    random_phase(120);
    write_reg(CfgLookMin, LookMinRst);
    write_reg(CfgLookMax, LookMaxRst);
    write_reg(CfgSwitch, SwitchRst);
    random_phase(100);

    $display("Ran %0d transfers in, %0d results, %0d position samples, %0d mismatches,",
             n_in, n_out, n_tracked, mismatches);
    $display("over five register settings including extremes and a long receiver hold-off.");
    if (mismatches == 0 && expected_guidance.size() == 0)
      $display("los_waypoint_path_guidance_unit_test OK");
    else
      $display("los_waypoint_path_guidance_unit_test NOT OK");
    $finish;
  end

endmodule
`default_nettype wire
